FILE: sv/a256ctr_pkg.sv
// ----------------------------------------------------------------------------
// a256ctr_pkg
// Shared types, constants and AES helper functions for the CTR-mode cipher.
// ----------------------------------------------------------------------------
package a256ctr_pkg;

  localparam int unsigned AesRounds = 14;

  typedef enum logic [2:0] {
    CFG_KEY_255_192 = 3'd0,
    CFG_KEY_191_128 = 3'd1,
    CFG_KEY_127_64  = 3'd2,
    CFG_KEY_63_0    = 3'd3,
    CFG_NONCE_UPPER = 3'd4,
    CFG_NONCE_LOWER = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_GEN,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        new_blk;
    logic [31:0] blk_idx;
  } q_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  localparam logic [0:2047] SboxBits = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SboxBits[{x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // Next four key schedule words from the sliding eight-word window
  function automatic logic [127:0] key_step(input logic [255:0] win,
                                            input logic [7:0] rcon,
                                            input logic rot);
    logic [31:0] t;
    logic [31:0] n0, n1, n2, n3;
    if (rot) begin
      t = sub_word({win[23:0], win[31:24]}) ^ {rcon, 24'h0};
    end else begin
      t = sub_word(win[31:0]);
    end
    n0 = win[255:224] ^ t;
    n1 = win[223:192] ^ n0;
    n2 = win[191:160] ^ n1;
    n3 = win[159:128] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // SubBytes, ShiftRows and, unless last round, MixColumns
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last_rnd);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3;
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c*4+r] = sbox(s[127 - 8*((((c + r) % 4) * 4) + r) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4];
      a1 = t[c*4+1];
      a2 = t[c*4+2];
      a3 = t[c*4+3];
      if (last_rnd) begin
        o[127 - 32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127 - 32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                               a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                               a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                               xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
      end
    end
    return o;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] count);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < count) begin
        m[63 - 8*b -: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

FILE: sv/a256ctr_intf.sv
// ----------------------------------------------------------------------------
// a256ctr channel interfaces
// Valid/ready channels for message words, result words and register writes.
// ----------------------------------------------------------------------------
interface a256ctr_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_in;
  logic [3:0]  byte_count;
  logic        last_word;
  modport source (output valid, data_in, byte_count, last_word, input ready);
  modport sink (input valid, data_in, byte_count, last_word, output ready);
endinterface

interface a256ctr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out;
  logic [3:0]  byte_count_out;
  logic        last_out;
  modport source (output valid, data_out, byte_count_out, last_out, input ready);
  modport sink (input valid, data_out, byte_count_out, last_out, output ready);
endinterface

interface a256ctr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/a256ctr_front.sv
// ----------------------------------------------------------------------------
// a256ctr_front
// Accepts message words, normalizes the byte count and tags keystream use.
// ----------------------------------------------------------------------------
module a256ctr_front
  import a256ctr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  a256ctr_in_if.sink    in_i,
  input  logic          full_i,
  output logic          push_o,
  output q_entry_t      entry_o
);

  logic [31:0] blk_idx_d, blk_idx_q;
  logic        wib_d, wib_q;
  logic        acc;

  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && !full_i;
  assign push_o     = acc;

  always_comb begin
    entry_o.data    = in_i.data_in;
    entry_o.count   = (in_i.byte_count == 4'd0 || in_i.byte_count > 4'd8) ? 4'd8
                                                                          : in_i.byte_count;
    entry_o.last    = in_i.last_word;
    entry_o.new_blk = !wib_q;
    entry_o.blk_idx = blk_idx_q;
  end

  always_comb begin
    blk_idx_d = blk_idx_q;
    wib_d     = wib_q;
    if (acc) begin
      if (wib_q) begin
        wib_d     = 1'b0;
        blk_idx_d = blk_idx_q + 32'd1;
      end else begin
        wib_d = 1'b1;
      end
      if (in_i.last_word) begin
        wib_d     = 1'b0;
        blk_idx_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_idx_q <= '0;
      wib_q     <= 1'b0;
    end else begin
      blk_idx_q <= blk_idx_d;
      wib_q     <= wib_d;
    end
  end

endmodule

FILE: sv/a256ctr_fifo.sv
// ----------------------------------------------------------------------------
// a256ctr_fifo
// Short queue of tagged words between the front and the back.
// ----------------------------------------------------------------------------
module a256ctr_fifo
  import a256ctr_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  function automatic logic [PtrW-1:0] adv(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= adv(wr_q);
      end
      if (pop_i) begin
        rd_q <= adv(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: sv/a256ctr_core.sv
// ----------------------------------------------------------------------------
// a256ctr_core
// Iterated AES-256 encryption, one round per cycle, key schedule on the fly.
// ----------------------------------------------------------------------------
module a256ctr_core
  import a256ctr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [255:0] key_i,
  input  logic [127:0] blk_i,
  output core_stat_t   stat_o,
  output logic [127:0] ks_o
);

  logic [127:0] st_q;
  logic [255:0] win_q;
  logic [7:0]   rcon_q;
  logic [3:0]   rnd_q;
  logic         busy_q, done_q;
  logic         last_rnd;

  assign last_rnd    = (rnd_q == 4'(AesRounds));
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign ks_o        = st_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      st_q   <= blk_i ^ key_i[255:128];
      win_q  <= key_i;
      rcon_q <= 8'h01;
    end else if (busy_q) begin
      st_q  <= aes_round(st_q, last_rnd) ^ win_q[127:0];
      win_q <= {win_q[127:0], key_step(win_q, rcon_q, rnd_q[0])};
      if (rnd_q[0]) begin
        rcon_q <= xtime(rcon_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rnd_q  <= 4'd1;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 4'd1;
        if (last_rnd) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/a256ctr_back.sv
// ----------------------------------------------------------------------------
// a256ctr_back
// Makes keystream blocks and combines them with queued words into results.
// ----------------------------------------------------------------------------
module a256ctr_back
  import a256ctr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  q_entry_t      q_entry_i,
  output logic          pop_o,
  input  logic [255:0]  key_i,
  input  logic [95:0]   nonce_i,
  a256ctr_out_if.source out_o
);

  back_state_e  state_d, state_q;
  core_stat_t   cstat;
  logic [127:0] ks;
  logic         start;
  logic         emit;
  logic         use_hi;
  logic         slot_free;
  logic         out_valid_q;
  logic [63:0]  data_q;
  logic [3:0]   count_q;
  logic         last_q;
  logic [63:0]  ks_half;

  a256ctr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .key_i  (key_i),
    .blk_i  ({nonce_i, q_entry_i.blk_idx}),
    .stat_o (cstat),
    .ks_o   (ks)
  );

  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i && q_entry_i.new_blk) begin
          state_d = B_GEN;
        end
      end
      B_GEN: begin
        if (cstat.done) begin
          state_d = B_EMIT;
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    start  = 1'b0;
    emit   = 1'b0;
    use_hi = 1'b0;
    case (state_q)
      B_IDLE: begin
        start = q_valid_i && q_entry_i.new_blk;
        emit  = q_valid_i && !q_entry_i.new_blk && slot_free;
      end
      B_EMIT: begin
        emit   = slot_free;
        use_hi = 1'b1;
      end
      default: ;
    endcase
  end

  assign pop_o   = emit;
  assign ks_half = use_hi ? ks[127:64] : ks[63:0];

  always_ff @(posedge clk_i) begin
    if (emit) begin
      data_q  <= (q_entry_i.data ^ ks_half) & byte_mask(q_entry_i.count);
      count_q <= q_entry_i.count;
      last_q  <= q_entry_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.data_out       = data_q;
  assign out_o.byte_count_out = count_q;
  assign out_o.last_out       = last_q;

endmodule

FILE: sv/aes256_ctr_stream_cipher.sv
// ----------------------------------------------------------------------------
// aes256_ctr_stream_cipher
// AES-256 counter-mode cipher over 64-bit message words.
// ----------------------------------------------------------------------------
// Channels: in_i takes message words (data_in, byte_count, last_word), out_o
// returns one result word per input word, in order; cfg_i writes the key and
// nonce registers by index and is always ready. Write registers only while
// the block is idle.
// Each 16-byte keystream block serves up to two words. The first word of a
// block waits for the iterated AES core (a start, the 14 rounds and the
// handoff) and takes the high half of the block; the second word takes the
// low half of the same block without waiting for the core. The single round
// unit and its handoff limit throughput: no new block is started until the
// first word of the last one has been emitted.
// A short queue lets the input side keep taking words while the core runs
// or while the receiver stalls; a stalled result holds in the output
// register. Reset clears the block index, the queue and all valid flags;
// key and nonce registers reset to zero.
// ----------------------------------------------------------------------------
module aes256_ctr_stream_cipher
  import a256ctr_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  a256ctr_cfg_if.sink   cfg_i,
  a256ctr_in_if.sink    in_i,
  a256ctr_out_if.source out_o
);

  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_hi_q;
  logic [31:0] nonce_lo_q;
  logic        push, full, pop, q_valid;
  q_entry_t    push_entry, q_entry;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q     <= '0;
      key1_q     <= '0;
      key2_q     <= '0;
      key3_q     <= '0;
      nonce_hi_q <= '0;
      nonce_lo_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_KEY_255_192: key0_q     <= cfg_i.data;
        CFG_KEY_191_128: key1_q     <= cfg_i.data;
        CFG_KEY_127_64:  key2_q     <= cfg_i.data;
        CFG_KEY_63_0:    key3_q     <= cfg_i.data;
        CFG_NONCE_UPPER: nonce_hi_q <= cfg_i.data;
        CFG_NONCE_LOWER: nonce_lo_q <= cfg_i.data[31:0];
        default: ;
      endcase
    end
  end

  a256ctr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .entry_o(push_entry)
  );

  a256ctr_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .entry_o(q_entry)
  );

  a256ctr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_entry_i(q_entry),
    .pop_o    (pop),
    .key_i    ({key0_q, key1_q, key2_q, key3_q}),
    .nonce_i  ({nonce_hi_q, nonce_lo_q}),
    .out_o    (out_o)
  );

endmodule

FILE: sv/a256ctr_chk.sv
// ----------------------------------------------------------------------------
// a256ctr_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module a256ctr_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_data_i,
  input logic [3:0]  out_count_i,
  input logic        out_last_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i) && $stable(out_count_i)
                                    && $stable(out_last_i))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_count_i != 4'd0 && out_count_i <= 4'd8)
    else $error("byte count out of range");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_count_i == 4'd1 |-> out_data_i[55:0] == 56'd0)
    else $error("bytes beyond count not zero");

endmodule

bind aes256_ctr_stream_cipher a256ctr_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data_out),
  .out_count_i(out_o.byte_count_out),
  .out_last_i (out_o.last_out)
);
